/* rtl/esc_pkg.sv */
// Shared constants for the epoch seconds to calendar converter.
// Holds the field widths, the reciprocal constants used in place of dividers
// and the cumulative month-start tables. Depends on nothing.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int unsigned PIPE_DEPTH = 8;

  // Field widths.
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned TZ_W     = 11;
  localparam int unsigned OFFS_W   = 17;  // offset in seconds, signed
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned DSEC_W   = 17;
  localparam int unsigned YDAY_W   = 9;
  localparam int unsigned YEAR_W   = 12;

  localparam logic [31:0] MAX_ADJ_SECONDS = 32'd4102444799;
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [11:0] BASE_YEAR       = 12'd1970;

  // Reciprocals: (x * RECIP) >> SHIFT gives the quotient, exact or one low
  // where a correction step follows.
  localparam logic [25:0] RECIP_DAY   = 26'd50903316;  // 1/675,  shift 35
  localparam logic [12:0] RECIP_HOUR  = 13'd4661;      // 1/225,  shift 20
  localparam logic [17:0] RECIP_CYCLE = 18'd183735;    // 1/1461, shift 28
  localparam logic [16:0] RECIP_WEEK  = 17'd74899;     // 1/7,    shift 19
  localparam logic [10:0] RECIP_MIN   = 11'd1093;      // 1/15,   shift 14

  localparam logic [8:0] COMMON_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [8:0] LEAP_START [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

  function automatic logic [8:0] month_first_yday(input logic leap, input logic [3:0] idx);
    logic [8:0] val;
    val = 9'd0;
    if (idx <= 4'd12) begin
      val = leap ? LEAP_START[idx] : COMMON_START[idx];
    end
    return val;
  endfunction

endpackage

/* rtl/epoch_seconds_to_calendar_top.sv */
// Epoch seconds to calendar converter: an eight-stage pipeline.
// done_o rises with the results of an accepted start in the output registers; throughput
// is one transaction per clock, set by the fully pipelined datapath.
// busy_o is always low because the receiver cannot stall and nothing is held.
// Reset clears the pipeline valid bits and sets the time-zone offset to zero.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [31:0]             epoch_seconds_i,
  input  logic                    cfg_we_i,
  input  logic signed [10:0]      cfg_wdata_i,
  output logic                    done_o,
  output logic [5:0]              second_o,
  output logic [5:0]              minute_o,
  output logic [4:0]              hour_o,
  output logic [4:0]              day_of_month_o,
  output logic [3:0]              month_number_o,
  output logic [11:0]             year_number_o,
  output logic [2:0]              day_of_week_o,
  output logic [8:0]              day_of_year_o,
  output logic                    clamped_o
);

  logic [esc_pkg::PIPE_DEPTH-1:0] valid_q, valid_d;
  logic                           accept;

  // Offset held in seconds so that the first stage is a single add.
  logic signed [esc_pkg::OFFS_W-1:0] offs_q, offs_d;

  // Stage 1: adjusted and clamped time.
  logic [31:0] s1_t_q, s1_t_d;
  logic        s1_clamp_q, s1_clamp_d;
  // Stage 2: estimated day count.
  logic [31:0] s2_t_q;
  logic [15:0] s2_q0_q, s2_q0_d;
  logic        s2_clamp_q;
  // Stage 3: uncorrected seconds of the day.
  logic [15:0] s3_q0_q;
  logic [17:0] s3_rem_q, s3_rem_d;
  logic        s3_clamp_q;
  // Stage 4: exact day count and seconds of the day.
  logic [15:0] s4_days_q, s4_days_d;
  logic [16:0] s4_dsec_q, s4_dsec_d;
  logic        s4_clamp_q;
  // Stage 5: hour, year index and week quotient.
  logic [15:0] s5_days_q;
  logic [16:0] s5_dsec_q;
  logic [4:0]  s5_hour_q, s5_hour_d;
  logic [7:0]  s5_y69_q, s5_y69_d;
  logic [12:0] s5_wq_q, s5_wq_d;
  logic        s5_clamp_q;
  // Stage 6: seconds of the hour, year, day of year, weekday.
  logic [4:0]  s6_hour_q;
  logic [11:0] s6_hrem_q, s6_hrem_d;
  logic [11:0] s6_year_q, s6_year_d;
  logic [8:0]  s6_yday_q, s6_yday_d;
  logic [2:0]  s6_wday_q, s6_wday_d;
  logic        s6_clamp_q;
  // Stage 7: minute and month.
  logic [4:0]  s7_hour_q;
  logic [11:0] s7_hrem_q;
  logic [5:0]  s7_min_q, s7_min_d;
  logic [3:0]  s7_month_q, s7_month_d;
  logic [11:0] s7_year_q;
  logic [8:0]  s7_yday_q;
  logic [2:0]  s7_wday_q;
  logic        s7_clamp_q;
  // Stage 8: output registers.
  logic [5:0]  s8_sec_d;
  logic [4:0]  s8_mday_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign valid_d = {valid_q[esc_pkg::PIPE_DEPTH-2:0], accept};

  always_comb begin
    offs_d = offs_q;
    if (cfg_we_i) begin
      // tz * 60 = tz * 64 - tz * 4
      offs_d = (esc_pkg::OFFS_W'(cfg_wdata_i) <<< 6) - (esc_pkg::OFFS_W'(cfg_wdata_i) <<< 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      offs_q  <= '0;
    end else begin
      valid_q <= valid_d;
      offs_q  <= offs_d;
    end
  end

  // Stage 1
  always_comb begin
    logic signed [33:0] adj;
    adj = $signed({2'b00, epoch_seconds_i}) + 34'(offs_q);
    s1_t_d     = adj[31:0];
    s1_clamp_d = 1'b0;
    if (adj < 0) begin
      s1_t_d     = '0;
      s1_clamp_d = 1'b1;
    end else if (adj > $signed({2'b00, esc_pkg::MAX_ADJ_SECONDS})) begin
      s1_t_d     = esc_pkg::MAX_ADJ_SECONDS;
      s1_clamp_d = 1'b1;
    end
  end

  // Stage 2: 86400 = 675 << 7, so divide the shifted time by 675.
  always_comb begin
    logic [50:0] prod;
    prod    = 51'(s1_t_q[31:7]) * 51'(esc_pkg::RECIP_DAY);
    s2_q0_d = prod[50:35];
  end

  // Stage 3: remainder against the estimate lies below twice a day.
  always_comb begin
    logic [31:0] diff;
    diff     = s2_t_q - 32'(s2_q0_q) * 32'(esc_pkg::SECS_PER_DAY);
    s3_rem_d = diff[17:0];
  end

  // Stage 4
  always_comb begin
    logic [17:0] fixed;
    fixed = s3_rem_q - 18'(esc_pkg::SECS_PER_DAY);
    if (s3_rem_q >= 18'(esc_pkg::SECS_PER_DAY)) begin
      s4_days_d = s3_q0_q + 16'd1;
      s4_dsec_d = fixed[16:0];
    end else begin
      s4_days_d = s3_q0_q;
      s4_dsec_d = s3_rem_q[16:0];
    end
  end

  // Stage 5: years are counted in four-year cycles from 1969, each cycle
  // ending with its leap year.
  always_comb begin
    logic [25:0] hprod;
    logic [17:0] yx;
    logic [35:0] yprod;
    logic [33:0] wprod;
    hprod     = 26'(s4_dsec_q[16:4]) * 26'(esc_pkg::RECIP_HOUR);
    yx        = {s4_days_q, 2'b00} + 18'd1463;
    yprod     = 36'(yx) * 36'(esc_pkg::RECIP_CYCLE);
    wprod     = 34'(17'(s4_days_q) + 17'd4) * 34'(esc_pkg::RECIP_WEEK);
    s5_hour_d = hprod[24:20];
    s5_y69_d  = yprod[35:28];
    s5_wq_d   = wprod[31:19];
  end

  // Stage 6
  always_comb begin
    logic [16:0] hsub;
    logic [7:0]  ey;
    logic [16:0] ybase;
    logic [15:0] ydiff;
    logic [16:0] wsub;
    hsub      = s5_dsec_q - 17'(s5_hour_q) * 17'(esc_pkg::SECS_PER_HOUR);
    ey        = s5_y69_q - 8'd1;
    ybase     = 17'(ey) * 17'd365 + 17'((ey + 8'd1) >> 2);
    ydiff     = s5_days_q - ybase[15:0];
    wsub      = (17'(s5_days_q) + 17'd4) - 17'(s5_wq_q) * 17'd7;
    s6_hrem_d = hsub[11:0];
    s6_year_d = esc_pkg::BASE_YEAR + 12'(ey);
    s6_yday_d = ydiff[8:0];
    s6_wday_d = wsub[2:0];
  end

  // Stage 7: the month is one more than the number of month starts passed.
  always_comb begin
    logic [20:0] mprod;
    logic        leap;
    logic [3:0]  cnt;
    mprod = 21'(s6_hrem_q[11:2]) * 21'(esc_pkg::RECIP_MIN);
    leap  = (s6_year_q[1:0] == 2'b00);
    cnt   = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s6_yday_q >= esc_pkg::month_first_yday(leap, 4'(m))) begin
        cnt = cnt + 4'd1;
      end
    end
    s7_min_d   = mprod[19:14];
    s7_month_d = cnt + 4'd1;
  end

  // Stage 8
  always_comb begin
    logic [11:0] ssub;
    logic [8:0]  dsub;
    logic        leap;
    leap      = (s7_year_q[1:0] == 2'b00);
    ssub      = s7_hrem_q - 12'(s7_min_q) * 12'd60;
    dsub      = s7_yday_q - esc_pkg::month_first_yday(leap, s7_month_q - 4'd1) + 9'd1;
    s8_sec_d  = ssub[5:0];
    s8_mday_d = dsub[4:0];
  end

  always_ff @(posedge clk_i) begin
    s1_t_q     <= s1_t_d;
    s1_clamp_q <= s1_clamp_d;

    s2_t_q     <= s1_t_q;
    s2_q0_q    <= s2_q0_d;
    s2_clamp_q <= s1_clamp_q;

    s3_q0_q    <= s2_q0_q;
    s3_rem_q   <= s3_rem_d;
    s3_clamp_q <= s2_clamp_q;

    s4_days_q  <= s4_days_d;
    s4_dsec_q  <= s4_dsec_d;
    s4_clamp_q <= s3_clamp_q;

    s5_days_q  <= s4_days_q;
    s5_dsec_q  <= s4_dsec_q;
    s5_hour_q  <= s5_hour_d;
    s5_y69_q   <= s5_y69_d;
    s5_wq_q    <= s5_wq_d;
    s5_clamp_q <= s4_clamp_q;

    s6_hour_q  <= s5_hour_q;
    s6_hrem_q  <= s6_hrem_d;
    s6_year_q  <= s6_year_d;
    s6_yday_q  <= s6_yday_d;
    s6_wday_q  <= s6_wday_d;
    s6_clamp_q <= s5_clamp_q;

    s7_hour_q  <= s6_hour_q;
    s7_hrem_q  <= s6_hrem_q;
    s7_min_q   <= s7_min_d;
    s7_month_q <= s7_month_d;
    s7_year_q  <= s6_year_q;
    s7_yday_q  <= s6_yday_q;
    s7_wday_q  <= s6_wday_q;
    s7_clamp_q <= s6_clamp_q;

    second_o       <= s8_sec_d;
    minute_o       <= s7_min_q;
    hour_o         <= s7_hour_q;
    day_of_month_o <= s8_mday_d;
    month_number_o <= s7_month_q;
    year_number_o  <= s7_year_q;
    day_of_week_o  <= s7_wday_q;
    day_of_year_o  <= s7_yday_q;
    clamped_o      <= s7_clamp_q;
  end

  assign done_o = valid_q[esc_pkg::PIPE_DEPTH-1];

endmodule
